[hw/rtl/sorted_table_insert_search_core_defines.svh]
// Assertion macros shared by the sorted table RTL.
`ifndef SORTED_TABLE_INSERT_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define STS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define STS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sts_pkg.sv]
// Types and constants of the sorted table block.
package sts_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int IDX_W    = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic METHOD_BINARY = 1'b0;
	localparam logic METHOD_FIB    = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] key;
		logic [IDX_W-1:0]   rank;
		logic [IDX_W-1:0]   range_low;
		logic [IDX_W-1:0]   range_high;
	} sts_req_t;

	typedef struct packed {
		logic signed [7:0]  result_rank;
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [CNT_W-1:0]   entry_count;
	} sts_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHIFT,
		S_INS_WR,
		S_FIB_GROW,
		S_FIB_SHRINK,
		S_PROBE_RD,
		S_PROBE_CMP,
		S_VAL_RD,
		S_VAL_WAIT,
		S_DONE
	} sts_state_t;

endpackage

[hw/rtl/sts_channels.sv]
// Handshake channel interfaces: request, response and configuration.
interface sts_req_if import sts_pkg::*; ();
	logic     valid;
	logic     ready;
	sts_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*; ();
	logic     valid;
	logic     ready;
	sts_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sts_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sorted_table_insert_search_core.sv]
// Sorted table of signed words: insert at rank, binary floor or Fibonacci exact search.
//
//  channel | dir | word                                               | taken when
//  req     | in  | operation, key, rank, range_low, range_high       | valid & ready
//  rsp     | out | result_rank, result_value, status, entry_count     | valid & ready
//  cfg     | in  | search_method (1 bit)                              | valid & ready
//
// Insert at rank r moves the entries from the top down to r up by one, one entry per
// cycle through the table RAM, then writes the key, then hands off. Errors go straight
// to hand-off. Binary search probes until the range is empty, then reads the value;
// Fibonacci first runs the sequence grow step, then passes through the shrink step
// (one pass up front and one more after each probe that misses) before each probe.
// The single-port-read table RAM sets the pace.
// req.ready is high only in idle; a finished word waits in the rsp register while
// the next request is accepted. A stalled rsp holds the block in its hand-off step.
// Reset clears count, method, state and rsp valid; table contents are not cleared.
`include "sorted_table_insert_search_core_defines.svh"

module sorted_table_insert_search_core
	import sts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sts_req_if.sink   req,
	sts_rsp_if.source rsp,
	sts_cfg_if.sink   cfg
);

	// table RAM, one write and one registered read per cycle
	logic signed [31:0] mem [CAPACITY];
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic signed [31:0] mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic signed [31:0] rd_data_q;

	sts_state_t state_q, state_d;

	logic               method_q;
	logic signed [31:0] key_q;
	logic [IDX_W-1:0]   rank_q;
	logic [IDX_W-1:0]   lo_q, lo_d;
	logic [IDX_W-1:0]   hi_q, hi_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               pend_q, pend_d;
	logic [IDX_W-1:0]   mid_q, mid_d;
	logic [IDX_W-1:0]   f_q, f_d;
	logic [IDX_W-1:0]   g_q, g_d;
	logic signed [7:0]  res_rank_q, res_rank_d;
	logic signed [31:0] res_value_q, res_value_d;
	logic [1:0]         status_q, status_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               rsp_valid_q;
	sts_rsp_t           rsp_data_q;
	logic               rsp_load;
	logic               req_take;

	// shared probe arithmetic
	logic [IDX_W:0]     mid_sum;
	logic [IDX_W-1:0]   probe_mid;
	logic [IDX_W-1:0]   span;
	logic               key_lt, key_gt;

	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid & req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	assign span      = hi_q - lo_q;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign probe_mid = (method_q == METHOD_BINARY) ? mid_sum[IDX_W:1] : lo_q + g_q - 1'b1;
	assign key_lt    = key_q < rd_data_q;
	assign key_gt    = rd_data_q < key_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			method_q    <= METHOD_BINARY;
			rsp_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			if (cfg.valid) begin
				method_q <= cfg.data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			key_q  <= req.data.key;
			rank_q <= req.data.rank;
		end
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		idx_q       <= idx_d;
		mid_q       <= mid_d;
		f_q         <= f_d;
		g_q         <= g_d;
		res_rank_q  <= res_rank_d;
		res_value_q <= res_value_d;
		status_q    <= status_d;
		if (rsp_load) begin
			rsp_data_q.result_rank  <= res_rank_q;
			rsp_data_q.result_value <= res_value_q;
			rsp_data_q.status       <= status_q;
			rsp_data_q.entry_count  <= count_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		idx_d       = idx_q;
		pend_d      = pend_q;
		mid_d       = mid_q;
		f_d         = f_q;
		g_d         = g_q;
		res_rank_d  = res_rank_q;
		res_value_d = res_value_q;
		status_d    = status_q;
		count_d     = count_q;
		mem_we      = 1'b0;
		mem_waddr   = idx_q[ADDR_W-1:0] + 1'b1;
		mem_wdata   = rd_data_q;
		mem_raddr   = '0;
		rsp_load    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_take) begin
					lo_d        = req.data.range_low;
					hi_d        = req.data.range_high;
					idx_d       = count_q;
					pend_d      = 1'b0;
					f_d         = IDX_W'(1);
					g_d         = '0;
					res_value_d = '0;
					status_d    = ST_OK;
					if (req.data.operation == OP_INSERT) begin
						res_rank_d = {1'b0, req.data.rank};
						if (count_q >= CNT_W'(CAPACITY)) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else if (req.data.rank > count_q) begin
							status_d = ST_BAD;
							state_d  = S_DONE;
						end else begin
							state_d = S_SHIFT;
						end
					end else begin
						res_rank_d = -8'sd1;
						if (req.data.range_low > req.data.range_high ||
								req.data.range_high > count_q) begin
							status_d = ST_BAD;
							state_d  = S_DONE;
						end else if (method_q == METHOD_BINARY) begin
							state_d = S_PROBE_RD;
						end else begin
							state_d = S_FIB_GROW;
						end
					end
				end
			end
			// move entries up: read idx-1 now, write it to idx next cycle
			S_SHIFT: begin
				mem_we = pend_q;
				if (idx_q > rank_q) begin
					mem_raddr = idx_q[ADDR_W-1:0] - 1'b1;
					pend_d    = 1'b1;
					idx_d     = idx_q - 1'b1;
				end else begin
					pend_d  = 1'b0;
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				mem_we      = 1'b1;
				mem_waddr   = rank_q[ADDR_W-1:0];
				mem_wdata   = key_q;
				count_d     = count_q + 1'b1;
				res_value_d = key_q;
				state_d     = S_DONE;
			end
			S_FIB_GROW: begin
				if (g_q < span) begin
					g_d = g_q + f_q;
					f_d = g_q;
				end else begin
					state_d = S_FIB_SHRINK;
				end
			end
			S_FIB_SHRINK: begin
				if (lo_q < hi_q && span < g_q) begin
					f_d = g_q - f_q;
					g_d = f_q;
				end else begin
					state_d = S_PROBE_RD;
				end
			end
			S_PROBE_RD: begin
				if (lo_q < hi_q) begin
					mid_d     = probe_mid;
					mem_raddr = probe_mid[ADDR_W-1:0];
					state_d   = S_PROBE_CMP;
				end else begin
					// floor result is low-1, exact search found nothing
					res_rank_d = (method_q == METHOD_BINARY) ? ({1'b0, lo_q} - 8'sd1) : -8'sd1;
					state_d    = S_VAL_RD;
				end
			end
			S_PROBE_CMP: begin
				if (method_q == METHOD_BINARY) begin
					if (key_lt) begin
						hi_d = mid_q;
					end else begin
						lo_d = mid_q + 1'b1;
					end
					state_d = S_PROBE_RD;
				end else begin
					priority if (key_lt) begin
						hi_d    = mid_q;
						state_d = S_FIB_SHRINK;
					end else if (key_gt) begin
						lo_d    = mid_q + 1'b1;
						state_d = S_FIB_SHRINK;
					end else begin
						res_rank_d = {1'b0, mid_q};
						state_d    = S_VAL_RD;
					end
				end
			end
			// a non-negative search result always lies below the count
			S_VAL_RD: begin
				mem_raddr = res_rank_q[ADDR_W-1:0];
				state_d   = S_VAL_WAIT;
			end
			S_VAL_WAIT: begin
				res_value_d = res_rank_q[7] ? 32'sd0 : rd_data_q;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`STS_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`STS_ASSERT_IMP(a_we_insert, mem_we, state_q == S_SHIFT || state_q == S_INS_WR, "table write outside insert")
	`STS_ASSERT_NXT(a_count_inc, state_q == S_INS_WR, count_q == $past(count_q) + 1'b1, "count not bumped on insert")
	`STS_ASSERT_NXT(a_count_hold, state_q != S_INS_WR, $stable(count_q), "count changed without insert")
	`STS_ASSERT_IMP(a_probe_range, state_q == S_PROBE_RD && lo_q < hi_q, probe_mid >= lo_q && probe_mid < hi_q, "probe outside search range")

endmodule

[bench/tb_top.sv]
// Self-checking bench for the sorted table core: insert and search words against a predictor.
module tb_top;
	import sts_pkg::*;

	// Scoreboard: mirrors the table, count and search method, and keeps the
	// responses still owed by the core, oldest first.
	class sorted_table_scoreboard;
		logic signed [31:0] slots [CAPACITY];
		int                 filled;
		logic               method;
		sts_rsp_t           owed_results [$];
		int                 mismatches;

		function new();
			foreach (slots[i])
				slots[i] = '0;
			filled     = 0;
			method     = METHOD_BINARY;
			mismatches = 0;
		endfunction

		// Largest rank in [lo, hi) whose value is not above k, else lo-1.
		function int floor_rank(logic signed [31:0] k, int lo, int hi);
			int mid;
			while (lo < hi) begin
				mid = (lo + hi) >>> 1;
				if (k < slots[mid])
					hi = mid;
				else
					lo = mid + 1;
			end
			return lo - 1;
		endfunction

		// Fibonacci probe sequence; rank of an equal value or -1.
		function int fib_rank(logic signed [31:0] k, int lo, int hi);
			int f;
			int g;
			int mid;
			f = 1;
			g = 0;
			while (g < hi - lo) begin
				g = g + f;
				f = g - f;
			end
			while (lo < hi) begin
				while (hi - lo < g) begin
					f = g - f;
					g = g - f;
				end
				mid = lo + g - 1;
				if (k < slots[mid])
					hi = mid;
				else if (slots[mid] < k)
					lo = mid + 1;
				else
					return mid;
			end
			return -1;
		endfunction

		// Applies one accepted request word and queues the response it owes.
		function void note_request(sts_req_t w);
			sts_rsp_t           r;
			logic signed [31:0] k;
			int                 rk;
			int                 lo;
			int                 hi;
			int                 found;
			k  = w.key;
			rk = int'(w.rank);
			lo = int'(w.range_low);
			hi = int'(w.range_high);
			r.result_value = '0;
			r.status       = ST_OK;
			if (w.operation == OP_INSERT) begin
				r.result_rank = 8'(rk);
				if (filled >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (rk > filled) begin
					r.status = ST_BAD;
				end else begin
					for (int i = filled; i > rk; i--)
						slots[i] = slots[i - 1];
					slots[rk]      = k;
					filled         = filled + 1;
					r.result_value = k;
				end
			end else begin
				if (lo > hi || hi > filled) begin
					r.result_rank = -8'sd1;
					r.status      = ST_BAD;
				end else begin
					found = (method == METHOD_BINARY) ? floor_rank(k, lo, hi) : fib_rank(k, lo, hi);
					r.result_rank = 8'(found);
					if (found >= 0 && found < filled)
						r.result_value = slots[found];
				end
			end
			r.entry_count = CNT_W'(filled);
			owed_results.push_back(r);
		endfunction

		// Compares one accepted response word, field by field, with the oldest one owed.
		function void check_result(sts_rsp_t got);
			sts_rsp_t e;
			if (owed_results.size() == 0) begin
				$display("%0t: response with none owed: rank %0d value %0d status %0d count %0d",
					$time, got.result_rank, got.result_value, got.status, got.entry_count);
				mismatches++;
				return;
			end
			e = owed_results.pop_front();
			if (got.result_rank !== e.result_rank) begin
				$display("%0t: result_rank expected %0d, got %0d", $time, e.result_rank,
					got.result_rank);
				mismatches++;
			end
			if (got.result_value !== e.result_value) begin
				$display("%0t: result_value expected %0d, got %0d", $time, e.result_value,
					got.result_value);
				mismatches++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d, got %0d", $time, e.status, got.status);
				mismatches++;
			end
			if (got.entry_count !== e.entry_count) begin
				$display("%0t: entry_count expected %0d, got %0d", $time, e.entry_count,
					got.entry_count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sts_req_if req_ch ();
	sts_rsp_if rsp_ch ();
	sts_cfg_if cfg_ch ();

	sorted_table_insert_search_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	sorted_table_scoreboard book;
	int unsigned            offered;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the core hangs.
	initial begin
		#1000000;
		$display("tb_top NOT OK");
		$finish;
	end

	// Builds one request word; fields the operation ignores are left at zero.
	function automatic sts_req_t req_word(logic op, logic signed [31:0] k, int rk, int lo,
			int hi);
		sts_req_t w;
		w.operation  = op;
		w.key        = k;
		w.rank       = IDX_W'(rk);
		w.range_low  = IDX_W'(lo);
		w.range_high = IDX_W'(hi);
		return w;
	endfunction

	// Keys: the extremes, a narrow band round zero to get duplicates, else anything.
	function automatic logic signed [31:0] draw_key();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	// Any rank that keeps the table ascending; ties land anywhere among equals.
	function automatic int sorted_rank(logic signed [31:0] k);
		int below;
		int not_above;
		below     = 0;
		not_above = 0;
		for (int i = 0; i < book.filled; i++) begin
			if (book.slots[i] < k)
				below++;
			if (book.slots[i] <= k)
				not_above++;
		end
		return $urandom_range(below, not_above);
	endfunction

	// Random word. Mostly well-formed: sorted inserts while the table fills, then a
	// few out-of-order ones near the top, and searches over legal ranges keyed off
	// stored values. The rest is out-of-range ranks and ranges. Ignored fields stay
	// random so every bit toggles.
	function automatic sts_req_t draw_request();
		sts_req_t w;
		int       pick;
		int       n;
		int       lo;
		int       hi;
		int       idx;
		int       nudge;
		n            = book.filled;
		w.operation  = OP_SEARCH;
		w.key        = draw_key();
		w.rank       = IDX_W'($urandom);
		w.range_low  = IDX_W'($urandom);
		w.range_high = IDX_W'($urandom);
		pick         = $urandom_range(0, 99);
		if (pick < 22) begin
			w.operation = OP_INSERT;
			if (n < CAPACITY && pick >= 2) begin
				if (n < CAPACITY - 4)
					w.rank = IDX_W'(sorted_rank(w.key));
				else
					w.rank = IDX_W'($urandom_range(0, n));
			end
		end else if (pick < 92) begin
			lo           = $urandom_range(0, n);
			hi           = $urandom_range(lo, n);
			w.range_low  = IDX_W'(lo);
			w.range_high = IDX_W'(hi);
			if (hi > lo && $urandom_range(0, 3) != 0) begin
				idx   = $urandom_range(lo, hi - 1);
				nudge = $urandom_range(0, 4);
				nudge = (nudge < 3) ? 0 : ((nudge == 3) ? -1 : 1);
				w.key = book.slots[idx] + 32'(nudge);
			end
		end
		return w;
	endfunction

	// Offers one word after a random gap. valid stays high afterwards so a
	// back-to-back word needs no drop; pause_until_drained lowers it.
	task automatic offer_request(sts_req_t w);
		int unsigned gap;
		gap = ((offered / 60) % 4 == 2) ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do
			@(posedge clk);
		while (!req_ch.ready);
		book.note_request(w);
		offered++;
	endtask

	// Stops offering and waits for every owed response, plus a short settle.
	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		while (book.owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write, only ever with the core drained.
	task automatic set_method(logic m);
		pause_until_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= m;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		book.method = m;
		cfg_ch.valid <= 1'b0;
	endtask

	// Response side: random stalls, stretches with none, and one long hold-off
	// so the core fills its output register and blocks new requests.
	initial begin : result_sink
		int unsigned hold;
		int unsigned taken;
		hold  = 0;
		taken = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				book.check_result(rsp_ch.data);
				taken++;
				if (taken == 250)
					hold = 300;
				else if ((taken / 40) % 4 == 1)
					hold = 0;
				else
					hold = $urandom_range(0, 10);
				if (hold != 0)
					rsp_ch.ready <= 1'b0;
			end else if (!rsp_ch.ready) begin
				if (hold != 0)
					hold--;
				if (hold == 0)
					rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		book    = new();
		offered = 0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, binary mode straight out of reset.
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 0, 0));       // empty range, empty table
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 0, 1));       // range end past count
		offer_request(req_word(OP_INSERT, 32'sd5, 1, 0, 0));       // rank past count
		offer_request(req_word(OP_INSERT, 32'sh8000_0000, 0, 0, 0));
		offer_request(req_word(OP_INSERT, 32'sh7fff_ffff, 1, 0, 0));
		offer_request(req_word(OP_INSERT, 32'sd0, 1, 0, 0));
		offer_request(req_word(OP_INSERT, 32'sd0, 1, 0, 0));       // duplicate value
		offer_request(req_word(OP_SEARCH, 32'sh8000_0000, 0, 0, 4));
		offer_request(req_word(OP_SEARCH, 32'sh7fff_ffff, 0, 0, 4));
		offer_request(req_word(OP_SEARCH, -32'sd1, 0, 0, 4));
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 1, 3));
		offer_request(req_word(OP_SEARCH, 32'sh8000_0000, 0, 1, 4)); // nothing below key
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 2, 2));       // empty range
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 3, 2));       // low above high
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 127, 127));   // both ends far out

		// Directed, Fibonacci mode.
		set_method(METHOD_FIB);
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 0, 4));
		offer_request(req_word(OP_SEARCH, 32'sd5, 0, 0, 4));       // miss
		offer_request(req_word(OP_SEARCH, 32'sh8000_0000, 0, 0, 4));
		offer_request(req_word(OP_SEARCH, 32'sh7fff_ffff, 0, 0, 4));
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 4, 4));       // empty range
		offer_request(req_word(OP_SEARCH, 32'sd0, 0, 4, 3));       // low above high
		offer_request(req_word(OP_INSERT, 32'sd7, 127, 0, 0));     // largest rank field

		// Random phases, alternating the search method between them. The table
		// fills early on; after that inserts report full and searches see all of it.
		for (int ph = 0; ph < 6; ph++) begin
			set_method((ph % 2 == 0) ? METHOD_BINARY : METHOD_FIB);
			for (int i = 0; i < 140; i++) begin
				if (ph == 3 && i == 70)
					pause_until_drained();
				offer_request(draw_request());
			end
		end

		pause_until_drained();
		repeat (20) @(posedge clk);
		if (book.mismatches == 0 && book.owed_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
